// File: hw/rtl/lpb_pkg.sv
// Package of the laser point to pixel box block: types, constants and helpers.
`default_nettype none
package lpb_pkg;

    localparam int IMAGE_WIDTH_DEF  = 1280;
    localparam int IMAGE_HEIGHT_DEF = 1024;

    localparam int DIST_W  = 24;
    localparam int TAG_W   = 16;
    localparam int BOX_W   = 11;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 3;
    localparam int CFG_N   = 8;

    localparam int QUO_W   = 49;
    localparam int DIV_W   = 24;

    localparam logic signed [24:0] OFF_UP     = 25'sd11141;
    localparam logic signed [24:0] OFF_FWD    = 25'sd4588;
    localparam logic [17:0]        EXT_SIDE   = 18'd32768;
    localparam logic [17:0]        EXT_UP     = 18'd78643;
    localparam logic [17:0]        EXT_DOWN   = 18'd117965;
    localparam int                 MARGIN     = 40;
    localparam logic signed [23:0] DEPTH_FAR  = 24'sd983040;
    localparam logic signed [23:0] DEPTH_NEAR = 24'sd131072;
    localparam logic signed [31:0] ONE_Q24    = 32'sd16777216;

    typedef enum logic [IDX_W-1:0] {
        REG_FOCAL_X   = 3'd0,
        REG_FOCAL_Y   = 3'd1,
        REG_CENTER_X  = 3'd2,
        REG_CENTER_Y  = 3'd3,
        REG_RADIAL_1  = 3'd4,
        REG_RADIAL_2  = 3'd5,
        REG_TANGENT_1 = 3'd6,
        REG_TANGENT_2 = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [23:0]        focal_x;
        logic [23:0]        focal_y;
        logic [23:0]        center_x;
        logic [23:0]        center_y;
        logic signed [31:0] radial_first;
        logic signed [31:0] radial_second;
        logic signed [31:0] tangent_first;
        logic signed [31:0] tangent_second;
    } cfg_t;

    // Saturate a 66-bit signed value to the 32-bit signed range.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sh0_0000_0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -66'sh0_0000_0000_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Product shifted right with floor, saturated.
    function automatic logic signed [31:0] shsat(input logic signed [63:0] p,
                                                 input logic sel28);
        logic signed [65:0] s;
        s = sel28 ? 66'(p >>> 28) : 66'(p >>> 24);
        return sat32(s);
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/lpb_if.sv
// Valid/ready channel interfaces of the block.
`default_nettype none
interface lpb_in_if;
    import lpb_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [DIST_W-1:0]  forward_dist;
    logic signed [DIST_W-1:0]  left_dist;
    logic signed [DIST_W-1:0]  up_dist;
    logic [TAG_W-1:0]          object_tag;
    modport source (output valid, forward_dist, left_dist, up_dist, object_tag, input ready);
    modport sink   (input valid, forward_dist, left_dist, up_dist, object_tag, output ready);
endinterface

interface lpb_out_if;
    import lpb_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [TAG_W-1:0]          tag_out;
    logic [BOX_W-1:0]          box_left;
    logic [BOX_W-1:0]          box_top;
    logic [BOX_W-1:0]          box_wide;
    logic [BOX_W-1:0]          box_tall;
    logic signed [DIST_W-1:0]  depth_out;
    logic                      credible;
    modport source (output valid, tag_out, box_left, box_top, box_wide, box_tall, depth_out,
                    credible, input ready);
    modport sink   (input valid, tag_out, box_left, box_top, box_wide, box_tall, depth_out,
                    credible, output ready);
endinterface

interface lpb_cfg_if;
    import lpb_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [CFG_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/lpb_div.sv
// Pipelined signed divider, truncating toward zero, one quotient bit per stage.
`default_nettype none
module lpb_div #(
    parameter int NW = 49,
    parameter int DW = 24,
    parameter int SW = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic signed [NW-1:0] num,
    input  wire logic signed [DW-1:0] den,
    input  wire logic [SW-1:0]        side_in,
    output logic signed [NW-1:0]      quo,
    output logic [SW-1:0]             side_out
);
    // Stage k settles quotient bit NW-1-k of |num| / |den|.
    logic [NW-1:0] rem_reg [NW+1];
    logic [NW-1:0] q_reg   [NW+1];
    logic [DW-1:0] d_reg   [NW+1];
    logic          neg_reg [NW+1];
    logic [SW-1:0] sd_reg  [NW+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num[NW-1] ? NW'(-num) : NW'(num);
            d_reg[0]   <= den[DW-1] ? DW'(-den) : DW'(den);
            neg_reg[0] <= num[NW-1] ^ den[DW-1];
            q_reg[0]   <= '0;
            sd_reg[0]  <= side_in;
        end
    end

    for (genvar k = 0; k < NW; k++)
    begin : g_stage
        logic [NW:0] part;
        logic        take;
        always_comb
        begin
            part = (NW+1)'(rem_reg[k] >> (NW-1-k));
            take = part >= (NW+1)'(d_reg[k]);
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= take ? rem_reg[k] - (NW'(d_reg[k]) << (NW-1-k)) : rem_reg[k];
                q_reg[k+1]   <= q_reg[k] | (NW'(take) << (NW-1-k));
                d_reg[k+1]   <= d_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                sd_reg[k+1]  <= sd_reg[k];
            end
        end
    end

    assign quo      = neg_reg[NW] ? NW'(-q_reg[NW]) : q_reg[NW];
    assign side_out = sd_reg[NW];

    logic unused_rst;
    assign unused_rst = rst_n;
endmodule
`default_nettype wire

// File: hw/rtl/laser_point_to_pixel_box.sv
// Top level of the laser point to pixel box block.
//
// Usage: points enter on the in channel (valid/ready), one item per clock while the out channel is not stalled.
// Each item is moved into camera axes, divided by depth in a pipelined
// divider, distorted, mapped to pixels and turned into a person box.
// Items that project outside the image, or have zero depth, are dropped
// inside the pipeline and produce no item on the out channel.
// The preparing stage is loaded at the edge that accepts an item; then
// follow 50 stages of the normalising division, ten stages that saturate,
// distort, project and form the extent numerators, a 44-stage division for
// the box extents and the output register.
// Throughput is one item per clock while no result waits on a stalled
// receiver; it is set by the fully pipelined dividers and multipliers.
// The pipeline advances as a whole; when the receiver stalls with a
// result waiting, the whole pipeline holds, so nothing is lost or repeated.
// Configuration writes on the cfg channel are always taken. Reset clears
// every valid bit and loads the default focal length and centre.
`default_nettype none
module laser_point_to_pixel_box
    import lpb_pkg::*;
#(
    parameter int IMAGE_WIDTH  = IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = IMAGE_HEIGHT_DEF
) (
    input wire logic  clk,
    input wire logic  rst_n,
    lpb_in_if.sink    in_ch,
    lpb_out_if.source out_ch,
    lpb_cfg_if.sink   cfg
);
    localparam int DL = QUO_W + 1;   // register stages of the divider
    localparam int SD = 3 * 32 + 2 * DIST_W + TAG_W + 1; // side band of the first divider

    cfg_t cfg_reg;
    logic en;

    // Whole-pipeline enable: advance unless a result waits on a stalled receiver.
    assign en = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = en;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.focal_x        <= 24'd256000;
            cfg_reg.focal_y        <= 24'd256000;
            cfg_reg.center_x       <= 24'd163840;
            cfg_reg.center_y       <= 24'd131072;
            cfg_reg.radial_first   <= '0;
            cfg_reg.radial_second  <= '0;
            cfg_reg.tangent_first  <= '0;
            cfg_reg.tangent_second <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (reg_idx_t'(cfg.index))
                REG_FOCAL_X:   cfg_reg.focal_x        <= cfg.data[23:0];
                REG_FOCAL_Y:   cfg_reg.focal_y        <= cfg.data[23:0];
                REG_CENTER_X:  cfg_reg.center_x       <= cfg.data[23:0];
                REG_CENTER_Y:  cfg_reg.center_y       <= cfg.data[23:0];
                REG_RADIAL_1:  cfg_reg.radial_first   <= cfg.data;
                REG_RADIAL_2:  cfg_reg.radial_second  <= cfg.data;
                REG_TANGENT_1: cfg_reg.tangent_first  <= cfg.data;
                REG_TANGENT_2: cfg_reg.tangent_second <= cfg.data;
                default: ;
            endcase
        end
    end

    // Stage 0: camera axes and the saturated depth.
    logic signed [24:0] cx_c, cy_c, cz_w;
    logic signed [23:0] cz_c;
    always_comb
    begin
        cx_c = -25'(in_ch.left_dist);
        cy_c = 25'(in_ch.up_dist) - OFF_UP;
        cz_w = 25'(in_ch.forward_dist) - OFF_FWD;
        if (cz_w > 25'sd8388607)       cz_c = 24'sh7FFFFF;
        else if (cz_w < -25'sd8388608) cz_c = 24'sh800000;
        else                           cz_c = cz_w[23:0];
    end

    logic               v0_reg;
    logic signed [24:0] cx0_reg, cy0_reg;
    logic signed [23:0] cz0_reg;
    logic [TAG_W-1:0]   tag0_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)  v0_reg <= 1'b0;
        else if (en) v0_reg <= in_ch.valid && cz_c != 0;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx0_reg <= cx_c; cy0_reg <= cy_c; cz0_reg <= cz_c; tag0_reg <= in_ch.object_tag;
        end
    end

    // Normalisation: xn and yn have one divider each; the divisor is the depth.
    logic signed [QUO_W-1:0] qx, qy;
    logic [SD-1:0] sdx_in, sdx_out;
    logic [0:0]    sdy_out;
    // The divider for y carries nothing but a spare bit; the side band rides the x divider.
    assign sdx_in = {96'd0, cz0_reg, 24'd0, tag0_reg, v0_reg};

    lpb_div #(.NW(QUO_W), .DW(DIV_W), .SW(SD)) u_div_x (
        .clk(clk), .rst_n(rst_n), .en(en),
        .num(QUO_W'(cx0_reg) <<< 24), .den(cz0_reg),
        .side_in(sdx_in), .quo(qx), .side_out(sdx_out)
    );
    lpb_div #(.NW(QUO_W), .DW(DIV_W), .SW(1)) u_div_y (
        .clk(clk), .rst_n(rst_n), .en(en),
        .num(QUO_W'(cy0_reg) <<< 24), .den(cz0_reg),
        .side_in(1'b0), .quo(qy), .side_out(sdy_out)
    );

    // Valid bits travel in flip-flops with reset alongside the divider.
    logic [DL-1:0] vdiv_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)  vdiv_reg <= '0;
        else if (en) vdiv_reg <= {vdiv_reg[DL-2:0], v0_reg};
    end

    logic signed [23:0] czd;
    logic [TAG_W-1:0]   tagd;
    assign czd  = sdx_out[TAG_W+1+24 +: 24];
    assign tagd = sdx_out[1 +: TAG_W];

    // Stage A: saturate xn, yn.
    logic               va_reg;
    logic signed [31:0] xn_reg, yn_reg;
    logic signed [23:0] cza_reg;
    logic [TAG_W-1:0]   taga_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)  va_reg <= 1'b0;
        else if (en) va_reg <= vdiv_reg[DL-1];
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xn_reg <= sat32(66'(qx)); yn_reg <= sat32(66'(qy));
            cza_reg <= czd; taga_reg <= tagd;
        end
    end

    // Stage B: squares and cross product.
    logic               vb_reg;
    logic signed [31:0] xnb_reg, ynb_reg, xx_reg, yy_reg, xy_reg;
    logic signed [23:0] czb_reg;
    logic [TAG_W-1:0]   tagb_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)  vb_reg <= 1'b0;
        else if (en) vb_reg <= va_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg <= shsat(64'(xn_reg) * 64'(xn_reg), 1'b0);
            yy_reg <= shsat(64'(yn_reg) * 64'(yn_reg), 1'b0);
            xy_reg <= shsat(64'(xn_reg) * 64'(yn_reg), 1'b0);
            xnb_reg <= xn_reg; ynb_reg <= yn_reg; czb_reg <= cza_reg; taga_pass: tagb_reg <= taga_reg;
        end
    end

    // Stage C: r2 and tangential arguments.
    logic               vc_reg;
    logic signed [31:0] xnc_reg, ync_reg, r2_reg, xyc_reg, ax_reg, ay_reg;
    logic signed [23:0] czc_reg;
    logic [TAG_W-1:0]   tagc_reg;
    logic signed [31:0] r2_c;
    assign r2_c = sat32(66'(xx_reg) + 66'(yy_reg));
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)  vc_reg <= 1'b0;
        else if (en) vc_reg <= vb_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r2_reg <= r2_c;
            ax_reg <= sat32(66'(r2_c) + 66'(xx_reg) + 66'(xx_reg));
            ay_reg <= sat32(66'(r2_c) + 66'(yy_reg) + 66'(yy_reg));
            xyc_reg <= xy_reg; xnc_reg <= xnb_reg; ync_reg <= ynb_reg;
            czc_reg <= czb_reg; tagc_reg <= tagb_reg;
        end
    end

    // Stage D: r4 and distortion products of r2, xy and the tangential arguments.
    logic               vd_reg;
    logic signed [31:0] xnd_reg, ynd_reg, r4_reg, k1r2_reg, p1xy_reg, p2ax_reg, p1ay_reg, p2xy_reg;
    logic signed [23:0] czd_reg;
    logic [TAG_W-1:0]   tagd_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)  vd_reg <= 1'b0;
        else if (en) vd_reg <= vc_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r4_reg   <= shsat(64'(r2_reg) * 64'(r2_reg), 1'b0);
            k1r2_reg <= shsat(64'(cfg_reg.radial_first) * 64'(r2_reg), 1'b1);
            p1xy_reg <= shsat(64'(cfg_reg.tangent_first) * 64'(xyc_reg), 1'b1);
            p2ax_reg <= shsat(64'(cfg_reg.tangent_second) * 64'(ax_reg), 1'b1);
            p1ay_reg <= shsat(64'(cfg_reg.tangent_first) * 64'(ay_reg), 1'b1);
            p2xy_reg <= shsat(64'(cfg_reg.tangent_second) * 64'(xyc_reg), 1'b1);
            xnd_reg <= xnc_reg; ynd_reg <= ync_reg; czd_reg <= czc_reg; tagd_reg <= tagc_reg;
        end
    end

    // Stage E: k2 term and the tangential sums.
    logic               ve_reg;
    logic signed [31:0] xne_reg, yne_reg, k1e_reg, k2r4_reg, tx_reg, ty_reg;
    logic signed [23:0] cze_reg;
    logic [TAG_W-1:0]   tage_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)  ve_reg <= 1'b0;
        else if (en) ve_reg <= vd_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k2r4_reg <= shsat(64'(cfg_reg.radial_second) * 64'(r4_reg), 1'b1);
            tx_reg <= sat32(66'(p1xy_reg) + 66'(p1xy_reg) + 66'(p2ax_reg));
            ty_reg <= sat32(66'(p1ay_reg) + 66'(p2xy_reg) + 66'(p2xy_reg));
            k1e_reg <= k1r2_reg;
            xne_reg <= xnd_reg; yne_reg <= ynd_reg; cze_reg <= czd_reg; tage_reg <= tagd_reg;
        end
    end

    // Stage F: radial factor.
    logic               vf_reg;
    logic signed [31:0] xnf_reg, ynf_reg, rad_reg, txf_reg, tyf_reg;
    logic signed [23:0] czf_reg;
    logic [TAG_W-1:0]   tagf_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)  vf_reg <= 1'b0;
        else if (en) vf_reg <= ve_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg <= sat32(66'(ONE_Q24) + 66'(k1e_reg) + 66'(k2r4_reg));
            txf_reg <= tx_reg; tyf_reg <= ty_reg;
            xnf_reg <= xne_reg; ynf_reg <= yne_reg; czf_reg <= cze_reg; tagf_reg <= tage_reg;
        end
    end

    // Stage G: distorted coordinates.
    logic               vg_reg;
    logic signed [31:0] xd_reg, yd_reg;
    logic signed [23:0] czg_reg;
    logic [TAG_W-1:0]   tagg_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)  vg_reg <= 1'b0;
        else if (en) vg_reg <= vf_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xd_reg <= sat32(66'(shsat(64'(rad_reg) * 64'(xnf_reg), 1'b0)) + 66'(txf_reg));
            yd_reg <= sat32(66'(shsat(64'(rad_reg) * 64'(ynf_reg), 1'b0)) + 66'(tyf_reg));
            czg_reg <= czf_reg; tagg_reg <= tagf_reg;
        end
    end

    // Stage H: pixel products (unsigned 24 by signed 32).
    logic               vh_reg;
    logic signed [57:0] pxp_reg, pyp_reg;
    logic signed [23:0] czh_reg;
    logic [TAG_W-1:0]   tagh_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)  vh_reg <= 1'b0;
        else if (en) vh_reg <= vg_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pxp_reg <= 58'($signed({1'b0, cfg_reg.focal_x})) * 58'(xd_reg)
                       + 58'($signed({1'b0, cfg_reg.center_x, 24'd0}));
            pyp_reg <= 58'($signed({1'b0, cfg_reg.focal_y})) * 58'(yd_reg)
                       + 58'($signed({1'b0, cfg_reg.center_y, 24'd0}));
            czh_reg <= czg_reg; tagh_reg <= tagg_reg;
        end
    end

    // Stage I: truncating divide by 2^32, row flip, image test.
    function automatic logic signed [25:0] trunc32(input logic signed [57:0] v);
        logic signed [57:0] a;
        a = v[57] ? v + 58'sh0_FFFF_FFFF : v;
        return 26'(a >>> 32);
    endfunction

    logic signed [25:0] px_c, py_c;
    logic               inside_c;
    always_comb
    begin
        px_c = trunc32(pxp_reg);
        py_c = 26'(IMAGE_HEIGHT) - trunc32(pyp_reg);
        inside_c = px_c > 0 && px_c < 26'(IMAGE_WIDTH) && py_c > 0 && py_c < 26'(IMAGE_HEIGHT);
    end

    logic               vi_reg;
    logic [12:0]        pxi_reg, pyi_reg;
    logic signed [23:0] czi_reg;
    logic [TAG_W-1:0]   tagi_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)  vi_reg <= 1'b0;
        else if (en) vi_reg <= vh_reg && inside_c;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pxi_reg <= px_c[12:0]; pyi_reg <= py_c[12:0];
            czi_reg <= czh_reg; tagi_reg <= tagh_reg;
        end
    end

    // Stage J: extent numerators ext*focal_x (42 bits).
    logic               vj_reg;
    logic [41:0]        ns_reg, nu_reg, nd_reg;
    logic [12:0]        pxj_reg, pyj_reg;
    logic signed [23:0] czj_reg;
    logic [TAG_W-1:0]   tagj_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)  vj_reg <= 1'b0;
        else if (en) vj_reg <= vi_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ns_reg <= 42'(EXT_SIDE) * 42'(cfg_reg.focal_x);
            nu_reg <= 42'(EXT_UP) * 42'(cfg_reg.focal_x);
            nd_reg <= 42'(EXT_DOWN) * 42'(cfg_reg.focal_x);
            pxj_reg <= pxi_reg; pyj_reg <= pyi_reg; czj_reg <= czi_reg; tagj_reg <= tagi_reg;
        end
    end

    // Extents: the numerator divided by depth (the factor 256 is a shift of the numerator).
    localparam int EW = 43;
    localparam int SE = 1 + 13 + 13 + 24 + TAG_W;
    logic signed [EW-1:0] hs_q, hu_q, hd_q;
    logic [SE-1:0] se_out;
    logic [0:0]    su_out, sd2_out;

    lpb_div #(.NW(EW), .DW(DIV_W), .SW(SE)) u_div_s (
        .clk(clk), .rst_n(rst_n), .en(en), .num(EW'(ns_reg >> 8)), .den(czj_reg),
        .side_in({vj_reg, pxj_reg, pyj_reg, czj_reg, tagj_reg}), .quo(hs_q), .side_out(se_out)
    );
    lpb_div #(.NW(EW), .DW(DIV_W), .SW(1)) u_div_u (
        .clk(clk), .rst_n(rst_n), .en(en), .num(EW'(nu_reg >> 8)), .den(czj_reg),
        .side_in(1'b0), .quo(hu_q), .side_out(su_out)
    );
    lpb_div #(.NW(EW), .DW(DIV_W), .SW(1)) u_div_d (
        .clk(clk), .rst_n(rst_n), .en(en), .num(EW'(nd_reg >> 8)), .den(czj_reg),
        .side_in(1'b0), .quo(hd_q), .side_out(sd2_out)
    );

    logic [EW:0] vext_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)  vext_reg <= '0;
        else if (en) vext_reg <= {vext_reg[EW-1:0], vj_reg};
    end

    // Final stage: box corners and sizes.
    logic signed [EW+1:0] px_e, py_e, lft_w, top_w, rgt_w, bot_w, wide_w, tall_w, lft_c, top_c;
    logic signed [23:0]   cz_e;
    always_comb
    begin
        px_e = (EW+2)'(se_out[SE-2 -: 13]);
        py_e = (EW+2)'(se_out[SE-15 -: 13]);
        cz_e = se_out[TAG_W +: 24];
        lft_w = px_e - (EW+2)'(hs_q) - (EW+2)'(MARGIN);
        top_w = py_e - (EW+2)'(hu_q) - (EW+2)'(MARGIN);
        rgt_w = px_e + (EW+2)'(hs_q) + (EW+2)'(MARGIN);
        bot_w = py_e + (EW+2)'(hd_q) + (EW+2)'(MARGIN);
        lft_c = lft_w < 0 ? '0 : (lft_w > (EW+2)'(IMAGE_WIDTH) ? (EW+2)'(IMAGE_WIDTH) : lft_w);
        top_c = top_w < 0 ? '0 : (top_w > (EW+2)'(IMAGE_HEIGHT) ? (EW+2)'(IMAGE_HEIGHT) : top_w);
        wide_w = (rgt_w > (EW+2)'(IMAGE_WIDTH) ? (EW+2)'(IMAGE_WIDTH) : rgt_w) - lft_c;
        tall_w = (bot_w > (EW+2)'(IMAGE_HEIGHT) ? (EW+2)'(IMAGE_HEIGHT) : bot_w) - top_c;
        if (wide_w < 0) wide_w = '0;
        if (tall_w < 0) tall_w = '0;
    end

    logic out_valid_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)  out_valid_reg <= 1'b0;
        else if (en) out_valid_reg <= vext_reg[EW];
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_ch.tag_out   <= se_out[TAG_W-1:0];
            out_ch.box_left  <= lft_c[BOX_W-1:0];
            out_ch.box_top   <= top_c[BOX_W-1:0];
            out_ch.box_wide  <= wide_w[BOX_W-1:0];
            out_ch.box_tall  <= tall_w[BOX_W-1:0];
            out_ch.depth_out <= cz_e;
            out_ch.credible  <= cz_e > DEPTH_NEAR && cz_e < DEPTH_FAR;
        end
    end
    assign out_ch.valid = out_valid_reg;

    logic unused_side;
    assign unused_side = ^{sdy_out, su_out, sd2_out, sdx_out[0], se_out[SE-1], sdx_out[SD-1 -: 96],
                           sdx_out[TAG_W+1 +: 24]};
endmodule
`default_nettype wire

// File: hw/rtl/lpb_checker.sv
// Port-level checker of the laser point to pixel box block and its bind.
`default_nettype none
module lpb_checker
    import lpb_pkg::*;
#(
    parameter int IMAGE_WIDTH  = IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = IMAGE_HEIGHT_DEF
) (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic               in_ready,
    input wire logic [BOX_W-1:0]   box_left,
    input wire logic [BOX_W-1:0]   box_wide,
    input wire logic [BOX_W-1:0]   box_top,
    input wire logic [BOX_W-1:0]   box_tall,
    input wire logic signed [23:0] depth_out,
    input wire logic               credible
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(box_left) && $stable(depth_out))
        else $error("result changed while stalled");
    a_width: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 12'(box_left) + 12'(box_wide) <= 12'(IMAGE_WIDTH))
        else $error("box beyond right edge");
    a_height: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 12'(box_top) + 12'(box_tall) <= 12'(IMAGE_HEIGHT))
        else $error("box beyond bottom edge");
    a_cred: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && credible |-> depth_out > DEPTH_NEAR && depth_out < DEPTH_FAR)
        else $error("credible flag disagrees with depth");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input refused with empty output");
endmodule

bind laser_point_to_pixel_box lpb_checker #(.IMAGE_WIDTH(IMAGE_WIDTH),
    .IMAGE_HEIGHT(IMAGE_HEIGHT)) u_lpb_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .in_ready(in_ch.ready), .box_left(out_ch.box_left), .box_wide(out_ch.box_wide),
    .box_top(out_ch.box_top), .box_tall(out_ch.box_tall), .depth_out(out_ch.depth_out),
    .credible(out_ch.credible)
);
`default_nettype wire
